// ===== rtl/core/segri_pkg.sv =====
// shared types, constants and helpers for the segment / rectangle intersection counter
package segri_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int CROSS_BITS  = PROD_BITS + 1;
    localparam int NUM_CORNERS = 4;
    localparam int COUNT_BITS  = 2;
    localparam int SUM_BITS    = 3;
    localparam int PIPE_DEPTH  = 5;

    // edge i runs from corner i to corner i+1 (wrapping)
    // corners: lower left, upper left, upper right, lower right
    localparam int EDGE_LEFT   = 0;
    localparam int EDGE_TOP    = 1;
    localparam int EDGE_RIGHT  = 2;
    localparam int EDGE_BOTTOM = 3;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef struct packed {
        coord_t rect_x_lo;
        coord_t rect_y_lo;
        coord_t rect_x_hi;
        coord_t rect_y_hi;
        coord_t seg_ax;
        coord_t seg_ay;
        coord_t seg_bx;
        coord_t seg_by;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] crossing_count;
        logic                  overlap;
    } out_item_t;

    // ordered rectangle and segment
    typedef struct packed {
        coord_t x0;
        coord_t x1;
        coord_t y0;
        coord_t y1;
        coord_t ax;
        coord_t ay;
        coord_t bx;
        coord_t by;
        coord_t ymin;
        coord_t ymax;
    } ord_t;

    typedef struct packed {
        logic [NUM_CORNERS-1:0] ba_zero;
        logic [NUM_CORNERS-1:0] ba_pos;
        logic [NUM_CORNERS-1:0] off;
        logic [NUM_CORNERS-1:0] touch;
        logic [NUM_CORNERS-1:0] box;
    } edge_flags_t;

    typedef struct packed {
        diff_t       dx;
        diff_t       dy;
        diff_t       cx0;
        diff_t       cx1;
        diff_t       cy0;
        diff_t       cy1;
        edge_flags_t flags;
    } prep_t;

    typedef struct packed {
        prod_t       dx_cy0;
        prod_t       dx_cy1;
        prod_t       dy_cx0;
        prod_t       dy_cx1;
        edge_flags_t flags;
    } mult_t;

    typedef struct packed {
        logic [NUM_CORNERS-1:0] neg;
        logic [NUM_CORNERS-1:0] zero;
        edge_flags_t            flags;
    } orient_t;

    function automatic logic pt_less(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        return (ax < bx) || ((ax == bx) && (ay < by));
    endfunction

    function automatic logic pt_eq(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        return (ax == bx) && (ay == by);
    endfunction

    function automatic diff_t coord_diff(coord_t a, coord_t b);
        return DIFF_BITS'(a) - DIFF_BITS'(b);
    endfunction

endpackage

// ===== rtl/core/segment_rectangle_intersection_count_unit.sv =====
// top level of the segment / rectangle boundary intersection counter
// one item per clock: an item taken with start is registered through the five
// register stages (ordering, differences and compares, the signed multipliers,
// the cross-product subtract, edge combination) and shows its result with done
// for one cycle; busy is held low because every stage advances each cycle and
// nothing ever stalls, so the receiver must take each result in the cycle it
// appears; no state is kept between items
module segment_rectangle_intersection_count_unit
    import segri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    // valid bits and payloads between stages
    logic    ord_valid;
    ord_t    ord;
    logic    prep_valid;
    prep_t   prep;
    logic    mult_valid;
    mult_t   mult;
    logic    orient_valid;
    orient_t orient;
    logic    accept;

    // the pipeline never holds off, so an item is taken whenever start is high
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // sort corners to (xmin,ymin)-(xmax,ymax) and the segment endpoints by x then y
    segri_order u_order
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_item   (item),
        .out_valid (ord_valid),
        .out_ord   (ord)
    );

    // differences for the cross products plus the comparisons that need no multiply
    segri_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ord_valid),
        .in_ord    (ord),
        .out_valid (prep_valid),
        .out_prep  (prep)
    );

    // four full-width products cover all four corners
    segri_mult u_mult
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_prep   (prep),
        .out_valid (mult_valid),
        .out_mult  (mult)
    );

    // exact orientation signs of the corners against the segment
    segri_cross u_cross
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mult_valid),
        .in_mult    (mult),
        .out_valid  (orient_valid),
        .out_orient (orient)
    );

    // edge tests, corner de-duplication, overlap override
    segri_edge u_edge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (orient_valid),
        .in_orient  (orient),
        .out_valid  (done),
        .out_result (result)
    );

endmodule

// ===== rtl/core/segri_order.sv =====
// first stage: orders rectangle corners and segment endpoints
module segri_order
    import segri_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  in_item_t in_item,
    output logic     out_valid,
    output ord_t     out_ord
);

    logic valid_reg;
    logic valid_next;
    ord_t ord_reg;
    ord_t ord_next;
    logic swap;

    always_comb
    begin
        valid_next = in_valid;
        swap = pt_less(in_item.seg_bx, in_item.seg_by, in_item.seg_ax, in_item.seg_ay);

        ord_next.x0 = (in_item.rect_x_lo > in_item.rect_x_hi) ? in_item.rect_x_hi
                                                             : in_item.rect_x_lo;
        ord_next.x1 = (in_item.rect_x_lo > in_item.rect_x_hi) ? in_item.rect_x_lo
                                                             : in_item.rect_x_hi;
        ord_next.y0 = (in_item.rect_y_lo > in_item.rect_y_hi) ? in_item.rect_y_hi
                                                             : in_item.rect_y_lo;
        ord_next.y1 = (in_item.rect_y_lo > in_item.rect_y_hi) ? in_item.rect_y_lo
                                                             : in_item.rect_y_hi;

        ord_next.ax = swap ? in_item.seg_bx : in_item.seg_ax;
        ord_next.ay = swap ? in_item.seg_by : in_item.seg_ay;
        ord_next.bx = swap ? in_item.seg_ax : in_item.seg_bx;
        ord_next.by = swap ? in_item.seg_ay : in_item.seg_by;

        // true y span of the segment for the bounding box test
        ord_next.ymin = (in_item.seg_ay < in_item.seg_by) ? in_item.seg_ay : in_item.seg_by;
        ord_next.ymax = (in_item.seg_ay < in_item.seg_by) ? in_item.seg_by : in_item.seg_ay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg <= ord_next;
    end

    assign out_valid = valid_reg;
    assign out_ord   = ord_reg;

endmodule

// ===== rtl/core/segri_prep.sv =====
// second stage: coordinate differences and per-edge comparison flags
module segri_prep
    import segri_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  ord_t  in_ord,
    output logic  out_valid,
    output prep_t out_prep
);

    logic  valid_reg;
    logic  valid_next;
    prep_t prep_reg;
    prep_t prep_next;

    coord_t cor_x [NUM_CORNERS];
    coord_t cor_y [NUM_CORNERS];
    coord_t e1x   [NUM_CORNERS];
    coord_t e1y   [NUM_CORNERS];
    coord_t e2x   [NUM_CORNERS];
    coord_t e2y   [NUM_CORNERS];
    logic   flat_w;
    logic   flat_h;

    always_comb
    begin
        valid_next = in_valid;

        cor_x[0] = in_ord.x0;  cor_y[0] = in_ord.y0;
        cor_x[1] = in_ord.x0;  cor_y[1] = in_ord.y1;
        cor_x[2] = in_ord.x1;  cor_y[2] = in_ord.y1;
        cor_x[3] = in_ord.x1;  cor_y[3] = in_ord.y0;

        // edge endpoints in lexicographic order
        e1x[EDGE_LEFT]   = in_ord.x0;  e1y[EDGE_LEFT]   = in_ord.y0;
        e2x[EDGE_LEFT]   = in_ord.x0;  e2y[EDGE_LEFT]   = in_ord.y1;
        e1x[EDGE_TOP]    = in_ord.x0;  e1y[EDGE_TOP]    = in_ord.y1;
        e2x[EDGE_TOP]    = in_ord.x1;  e2y[EDGE_TOP]    = in_ord.y1;
        e1x[EDGE_RIGHT]  = in_ord.x1;  e1y[EDGE_RIGHT]  = in_ord.y0;
        e2x[EDGE_RIGHT]  = in_ord.x1;  e2y[EDGE_RIGHT]  = in_ord.y1;
        e1x[EDGE_BOTTOM] = in_ord.x0;  e1y[EDGE_BOTTOM] = in_ord.y0;
        e2x[EDGE_BOTTOM] = in_ord.x1;  e2y[EDGE_BOTTOM] = in_ord.y0;

        prep_next.dx  = coord_diff(in_ord.bx, in_ord.ax);
        prep_next.dy  = coord_diff(in_ord.by, in_ord.ay);
        prep_next.cx0 = coord_diff(in_ord.x0, in_ord.ax);
        prep_next.cx1 = coord_diff(in_ord.x1, in_ord.ax);
        prep_next.cy0 = coord_diff(in_ord.y0, in_ord.ay);
        prep_next.cy1 = coord_diff(in_ord.y1, in_ord.ay);

        flat_w = (in_ord.x0 == in_ord.x1);
        flat_h = (in_ord.y0 == in_ord.y1);

        // side of each segment endpoint relative to the edge's line
        prep_next.flags.ba_zero[EDGE_LEFT] = flat_h || (in_ord.ax == in_ord.x0)
                                             || (in_ord.bx == in_ord.x0);
        prep_next.flags.ba_pos[EDGE_LEFT] = !prep_next.flags.ba_zero[EDGE_LEFT]
            && ((in_ord.ax < in_ord.x0) == (in_ord.bx < in_ord.x0));
        prep_next.flags.ba_zero[EDGE_RIGHT] = flat_h || (in_ord.ax == in_ord.x1)
                                              || (in_ord.bx == in_ord.x1);
        prep_next.flags.ba_pos[EDGE_RIGHT] = !prep_next.flags.ba_zero[EDGE_RIGHT]
            && ((in_ord.ax < in_ord.x1) == (in_ord.bx < in_ord.x1));
        prep_next.flags.ba_zero[EDGE_TOP] = flat_w || (in_ord.ay == in_ord.y1)
                                            || (in_ord.by == in_ord.y1);
        prep_next.flags.ba_pos[EDGE_TOP] = !prep_next.flags.ba_zero[EDGE_TOP]
            && ((in_ord.ay < in_ord.y1) == (in_ord.by < in_ord.y1));
        prep_next.flags.ba_zero[EDGE_BOTTOM] = flat_w || (in_ord.ay == in_ord.y0)
                                               || (in_ord.by == in_ord.y0);
        prep_next.flags.ba_pos[EDGE_BOTTOM] = !prep_next.flags.ba_zero[EDGE_BOTTOM]
            && ((in_ord.ay < in_ord.y0) == (in_ord.by < in_ord.y0));

        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            // collinear case: disjoint or touching at an end
            prep_next.flags.off[i] = pt_less(e2x[i], e2y[i], in_ord.ax, in_ord.ay)
                                  || pt_less(in_ord.bx, in_ord.by, e1x[i], e1y[i]);
            prep_next.flags.touch[i] = pt_eq(in_ord.ax, in_ord.ay, e2x[i], e2y[i])
                                    || pt_eq(in_ord.bx, in_ord.by, e1x[i], e1y[i]);
            // corner inside the segment's bounding box
            prep_next.flags.box[i] = (in_ord.ax <= cor_x[i]) && (cor_x[i] <= in_ord.bx)
                                  && (in_ord.ymin <= cor_y[i]) && (cor_y[i] <= in_ord.ymax);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prep_reg <= prep_next;
    end

    assign out_valid = valid_reg;
    assign out_prep  = prep_reg;

endmodule

// ===== rtl/core/segri_mult.sv =====
// third stage: the four cross-product partial products
module segri_mult
    import segri_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  prep_t in_prep,
    output logic  out_valid,
    output mult_t out_mult
);

    logic  valid_reg;
    logic  valid_next;
    mult_t mult_reg;
    mult_t mult_next;

    always_comb
    begin
        valid_next       = in_valid;
        mult_next.dx_cy0 = PROD_BITS'(in_prep.dx) * PROD_BITS'(in_prep.cy0);
        mult_next.dx_cy1 = PROD_BITS'(in_prep.dx) * PROD_BITS'(in_prep.cy1);
        mult_next.dy_cx0 = PROD_BITS'(in_prep.dy) * PROD_BITS'(in_prep.cx0);
        mult_next.dy_cx1 = PROD_BITS'(in_prep.dy) * PROD_BITS'(in_prep.cx1);
        mult_next.flags  = in_prep.flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mult_reg <= mult_next;
    end

    assign out_valid = valid_reg;
    assign out_mult  = mult_reg;

endmodule

// ===== rtl/core/segri_cross.sv =====
// fourth stage: orientation sign of each corner against the segment
module segri_cross
    import segri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  mult_t   in_mult,
    output logic    out_valid,
    output orient_t out_orient
);

    logic    valid_reg;
    logic    valid_next;
    orient_t orient_reg;
    orient_t orient_next;
    cross_t  cr [NUM_CORNERS];

    always_comb
    begin
        valid_next = in_valid;
        cr[0] = CROSS_BITS'(in_mult.dx_cy0) - CROSS_BITS'(in_mult.dy_cx0);
        cr[1] = CROSS_BITS'(in_mult.dx_cy1) - CROSS_BITS'(in_mult.dy_cx0);
        cr[2] = CROSS_BITS'(in_mult.dx_cy1) - CROSS_BITS'(in_mult.dy_cx1);
        cr[3] = CROSS_BITS'(in_mult.dx_cy0) - CROSS_BITS'(in_mult.dy_cx1);
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            orient_next.neg[i]  = cr[i][CROSS_BITS-1];
            orient_next.zero[i] = (cr[i] == '0);
        end
        orient_next.flags = in_mult.flags;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        orient_reg <= orient_next;
    end

    assign out_valid  = valid_reg;
    assign out_orient = orient_reg;

endmodule

// ===== rtl/core/segri_edge.sv =====
// last stage: per-edge hit decision, corner de-duplication and result register
module segri_edge
    import segri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  orient_t   in_orient,
    output logic      out_valid,
    output out_item_t out_result
);

    logic                   valid_reg;
    logic                   valid_next;
    out_item_t              result_reg;
    out_item_t              result_next;
    logic [NUM_CORNERS-1:0] ab_zero;
    logic [NUM_CORNERS-1:0] ab_pos;
    logic [NUM_CORNERS-1:0] coll;
    logic [NUM_CORNERS-1:0] over;
    logic [NUM_CORNERS-1:0] hit;
    logic [NUM_CORNERS-1:0] counted;
    logic [SUM_BITS-1:0]    sum;
    logic [1:0]             j;

    always_comb
    begin
        valid_next = in_valid;
        sum        = '0;
        for (int i = 0; i < NUM_CORNERS; i++)
        begin
            // next corner round the rectangle, wraps from the last to the first
            j = 2'(i + 1);
            ab_zero[i] = in_orient.zero[i] || in_orient.zero[j];
            ab_pos[i]  = !ab_zero[i] && (in_orient.neg[i] == in_orient.neg[j]);
            coll[i]    = ab_zero[i] && in_orient.flags.ba_zero[i];
            over[i]    = coll[i] && !in_orient.flags.off[i] && !in_orient.flags.touch[i];
            hit[i]     = coll[i] ? (!in_orient.flags.off[i] && in_orient.flags.touch[i])
                                 : (!ab_pos[i] && !in_orient.flags.ba_pos[i]);
            // a hit is dropped when the edge's starting corner lies on the segment
            counted[i] = hit[i] && !(in_orient.zero[i] && in_orient.flags.box[i]);
            sum        = sum + SUM_BITS'(counted[i]);
        end

        if (|over)
        begin
            result_next.overlap        = 1'b1;
            result_next.crossing_count = '0;
        end
        else
        begin
            result_next.overlap        = 1'b0;
            result_next.crossing_count = sum[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== rtl/core/segri_checker.sv =====
// port-level checks for the intersection counter and their bind
module segri_checker
    import segri_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_item_t result
);

    // the pipeline never refuses an item
    a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // each accepted item yields a result
    a_result_follows : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("result missing for accepted item");

    // no result without an earlier accepted item
    a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without accepted item");

    // an overlap reports no crossing count
    a_overlap_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overlap) |-> (result.crossing_count == '0))
        else $error("overlap with nonzero count");

endmodule

bind segment_rectangle_intersection_count_unit segri_checker u_segri_checker (.*);
